>>> src/text_console_output_macros.svh
// ----------------------------------------------------------------------------
// Text console output - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_OUTPUT_MACROS_SVH
`define TEXT_CONSOLE_OUTPUT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("text console check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("text console check failed");

`endif

>>> src/tco_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Types and constants shared by the text console modules.
// ----------------------------------------------------------------------------
package tco_pkg;

    localparam int MEM_CELLS = 2048;
    localparam int ADDR_W    = 11;
    localparam int PTR_W     = 12;

    localparam int CELLS_NARROW = 1024;
    localparam int CELLS_WIDE   = 1920;
    localparam int COLS_NARROW  = 64;
    localparam int COLS_WIDE    = 80;

    // Start of the last line of each screen format.
    localparam int LAST_NARROW = (CELLS_NARROW / COLS_NARROW - 1) * COLS_NARROW;
    localparam int LAST_WIDE   = (CELLS_WIDE / COLS_WIDE - 1) * COLS_WIDE;

    // pos / 80 equals (pos * RECIP_80) >> RECIP_SHIFT for every pos below 2048.
    localparam int RECIP_80    = 3277;
    localparam int RECIP_SHIFT = 18;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [1:0] CFG_WIDE   = 2'd0;
    localparam logic [1:0] CFG_SCROLL = 2'd1;
    localparam logic [1:0] CFG_UPPER  = 2'd2;

    typedef enum logic [1:0] {
        CMD_PUT_CHAR   = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_READ_CELL  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic              wide;
        logic [ADDR_W-1:0] scroll_start;
        logic              upper;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [7:0]        data;
        logic [ADDR_W-1:0] cursor;
        logic              scrolled;
        logic              bad;
    } t_result;

endpackage

>>> src/tco_screen_mem.sv
// ----------------------------------------------------------------------------
// Text console screen memory
// 2048 x 8 character store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tco_screen_mem (
    input  logic              i_clk,
    input  tco_pkg::t_mem_req i_req,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [tco_pkg::MEM_CELLS];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/tco_seq.sv
// ----------------------------------------------------------------------------
// Text console sequencer
// Command decode, cursor arithmetic and the shared address sweep that clears,
// fills and scrolls the screen memory one cell per cycle.
// ----------------------------------------------------------------------------
module tco_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_cmd,
    input  logic [7:0]                  i_char_code,
    input  logic [6:0]                  i_column,
    input  logic [4:0]                  i_row,
    input  logic [tco_pkg::ADDR_W-1:0]  i_cell_address,
    input  tco_pkg::t_cfg               i_cfg,
    input  logic [7:0]                  i_rd_data,
    output logic                        o_busy,
    output tco_pkg::t_mem_req           o_mem_req,
    output tco_pkg::t_result            o_result
);

    localparam int AW = tco_pkg::ADDR_W;
    localparam int PW = tco_pkg::PTR_W;
    localparam int PROD_W = AW + 12;

    typedef enum logic [10:0] {
        ST_INIT      = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_EXEC      = 11'b000_0000_0100,
        ST_QUOT      = 11'b000_0000_1000,
        ST_NEXTL     = 11'b000_0001_0000,
        ST_BLANK     = 11'b000_0010_0000,
        ST_MOVE      = 11'b000_0100_0000,
        ST_MOVE_TAIL = 11'b000_1000_0000,
        ST_FILL      = 11'b001_0000_0000,
        ST_READ      = 11'b010_0000_0000,
        ST_DONE      = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_cur, n_cur;
    logic              r_mv_pend, n_mv_pend;
    logic [PW-1:0]     r_end, n_end;
    logic [AW-1:0]     r_mv_dst, n_mv_dst;
    logic [4:0]        r_quo, n_quo;
    logic              r_lf_blank, n_lf_blank;
    logic              r_then_adv, n_then_adv;
    tco_pkg::t_cmd     r_cmd, n_cmd;
    logic [7:0]        r_ch, n_ch;
    logic [6:0]        r_col, n_col;
    logic [4:0]        r_row, n_row;
    logic [AW-1:0]     r_addr, n_addr;
    logic [7:0]        r_data, n_data;
    logic              r_scr, n_scr;
    logic              r_bad, n_bad;

    logic [6:0]        w_cols;
    logic [PW-1:0]     s_cells;
    logic [AW-1:0]     last_line;
    logic [PW-1:0]     cur_inc;
    logic [PW-1:0]     ptr_inc;
    logic [PW-1:0]     set_pos;
    logic [PROD_W-1:0] quo_prod;
    logic [5:0]        quo_inc;
    logic [PW-1:0]     nls;
    logic [PW-1:0]     nls_cap;
    logic [PW-1:0]     ss_plus_w;
    logic [7:0]        ch_store;

    // Screen geometry for the selected format.
    assign w_cols    = i_cfg.wide ? 7'(tco_pkg::COLS_WIDE) : 7'(tco_pkg::COLS_NARROW);
    assign s_cells   = i_cfg.wide ? PW'(tco_pkg::CELLS_WIDE) : PW'(tco_pkg::CELLS_NARROW);
    assign last_line = i_cfg.wide ? AW'(tco_pkg::LAST_WIDE) : AW'(tco_pkg::LAST_NARROW);

    assign cur_inc   = {1'b0, r_cur} + PW'(1);
    assign ptr_inc   = r_ptr + PW'(1);
    assign ss_plus_w = {1'b0, i_cfg.scroll_start} + PW'(w_cols);

    // row * W + column, with W = 64, or on the wide screen W = 80 built as 64 + 16.
    assign set_pos = PW'({r_row, 6'b0}) + PW'(r_col)
                   + (i_cfg.wide ? PW'({r_row, 4'b0}) : PW'(0));

    // Line number of the cursor; registered in ST_QUOT.
    assign quo_prod = PROD_W'(r_cur) * PROD_W'(tco_pkg::RECIP_80);

    // Start of the line after the cursor's line.
    assign quo_inc = {1'b0, r_quo} + 6'd1;
    assign nls     = PW'({quo_inc, 6'b0}) + (i_cfg.wide ? PW'({quo_inc, 4'b0}) : PW'(0));
    assign nls_cap = (nls > PW'(tco_pkg::MEM_CELLS)) ? PW'(tco_pkg::MEM_CELLS) : nls;

    assign ch_store = (i_cfg.upper && r_ch >= tco_pkg::CH_LOWER_A
                       && r_ch <= tco_pkg::CH_LOWER_Z) ? r_ch - tco_pkg::CASE_OFFSET : r_ch;

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_cur      = r_cur;
        n_end      = r_end;
        n_mv_pend  = (r_state == ST_MOVE);
        n_mv_dst   = AW'(r_ptr - PW'(w_cols));
        n_quo      = r_quo;
        n_lf_blank = r_lf_blank;
        n_then_adv = r_then_adv;
        n_cmd      = r_cmd;
        n_ch       = r_ch;
        n_col      = r_col;
        n_row      = r_row;
        n_addr     = r_addr;
        n_data     = r_data;
        n_scr      = r_scr;
        n_bad      = r_bad;

        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_ptr[AW-1:0];
        o_mem_req.wdata = tco_pkg::CH_SPACE;
        o_mem_req.raddr = (r_state == ST_MOVE) ? r_ptr[AW-1:0] : r_addr;

        unique case (r_state)
            ST_INIT: begin
                o_mem_req.we = 1'b1;
                n_ptr        = ptr_inc;
                if (ptr_inc == PW'(tco_pkg::MEM_CELLS)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd   = tco_pkg::t_cmd'(i_cmd);
                    n_ch    = i_char_code;
                    n_col   = i_column;
                    n_row   = i_row;
                    n_addr  = i_cell_address;
                    n_data  = 8'd0;
                    n_scr   = 1'b0;
                    n_bad   = 1'b0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_cmd)
                    tco_pkg::CMD_PUT_CHAR: begin
                        priority if (r_ch == tco_pkg::CH_BACKSPACE) begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = r_cur;
                            if (r_cur != '0) begin
                                n_cur = r_cur - AW'(1);
                            end
                            n_state = ST_DONE;
                        end else if (r_ch == tco_pkg::CH_RETURN) begin
                            n_state = ST_DONE;
                        end else if (r_ch == tco_pkg::CH_NEWLINE) begin
                            n_lf_blank = 1'b1;
                            n_state    = ST_QUOT;
                        end else begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = r_cur;
                            o_mem_req.wdata = ch_store;
                            if (cur_inc >= s_cells) begin
                                n_lf_blank = 1'b0;
                                n_state    = ST_QUOT;
                            end else begin
                                n_cur   = cur_inc[AW-1:0];
                                n_state = ST_DONE;
                            end
                        end
                    end
                    tco_pkg::CMD_SET_CURSOR: begin
                        if (r_col >= w_cols || set_pos >= s_cells) begin
                            n_bad = 1'b1;
                        end else begin
                            n_cur = set_pos[AW-1:0];
                        end
                        n_state = ST_DONE;
                    end
                    tco_pkg::CMD_CLEAR: begin
                        n_ptr   = '0;
                        n_end   = s_cells;
                        n_state = ST_FILL;
                    end
                    tco_pkg::CMD_READ_CELL: begin
                        if ({1'b0, r_addr} >= s_cells) begin
                            n_bad   = 1'b1;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_QUOT: begin
                n_quo   = i_cfg.wide ? quo_prod[tco_pkg::RECIP_SHIFT +: 5] : r_cur[AW-1 -: 5];
                n_state = ST_NEXTL;
            end
            ST_NEXTL: begin
                if (r_lf_blank) begin
                    n_ptr      = {1'b0, r_cur};
                    n_end      = nls_cap;
                    n_lf_blank = 1'b0;
                    n_then_adv = 1'b1;
                    n_state    = ST_BLANK;
                end else if (nls < s_cells) begin
                    n_cur   = nls[AW-1:0];
                    n_state = ST_DONE;
                end else begin
                    n_scr = 1'b1;
                    if (ss_plus_w < s_cells) begin
                        n_ptr   = ss_plus_w;
                        n_end   = s_cells;
                        n_state = ST_MOVE;
                    end else begin
                        n_cur      = last_line;
                        n_ptr      = {1'b0, last_line};
                        n_end      = {1'b0, last_line} + PW'(w_cols);
                        n_then_adv = 1'b0;
                        n_state    = ST_BLANK;
                    end
                end
            end
            ST_BLANK: begin
                o_mem_req.we = 1'b1;
                n_ptr        = ptr_inc;
                if (ptr_inc == r_end) begin
                    n_state = r_then_adv ? ST_NEXTL : ST_DONE;
                end
            end
            ST_MOVE: begin
                // Reads run one cell ahead of the writes, one line lower down.
                o_mem_req.we    = r_mv_pend;
                o_mem_req.waddr = r_mv_dst;
                o_mem_req.wdata = i_rd_data;
                n_ptr           = ptr_inc;
                if (ptr_inc == r_end) begin
                    n_state = ST_MOVE_TAIL;
                end
            end
            ST_MOVE_TAIL: begin
                o_mem_req.we    = r_mv_pend;
                o_mem_req.waddr = r_mv_dst;
                o_mem_req.wdata = i_rd_data;
                n_cur           = last_line;
                n_ptr           = {1'b0, last_line};
                n_end           = {1'b0, last_line} + PW'(w_cols);
                n_then_adv      = 1'b0;
                n_state         = ST_BLANK;
            end
            ST_FILL: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.wdata = r_ch;
                n_ptr           = ptr_inc;
                if (ptr_inc == r_end) begin
                    n_cur   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_data  = i_rd_data;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_ptr     <= '0;
            r_cur     <= '0;
            r_mv_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_cur     <= n_cur;
            r_mv_pend <= n_mv_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end      <= n_end;
        r_mv_dst   <= n_mv_dst;
        r_quo      <= n_quo;
        r_lf_blank <= n_lf_blank;
        r_then_adv <= n_then_adv;
        r_cmd      <= n_cmd;
        r_ch       <= n_ch;
        r_col      <= n_col;
        r_row      <= n_row;
        r_addr     <= n_addr;
        r_data     <= n_data;
        r_scr      <= n_scr;
        r_bad      <= n_bad;
    end

    assign o_busy = (r_state != ST_IDLE);

    assign o_result.valid    = (r_state == ST_DONE);
    assign o_result.data     = r_data;
    assign o_result.cursor   = r_cur;
    assign o_result.scrolled = r_scr;
    assign o_result.bad      = r_bad;

endmodule

>>> src/text_console_output.sv
// ----------------------------------------------------------------------------
// Text console output
// Character-cell console: 2048-cell screen memory, cursor and scrolling.
// ----------------------------------------------------------------------------
// A request is offered on start with its fields on i_cmd, i_char_code,
// i_column, i_row and i_cell_address, and is taken at a clock edge where start
// is high and busy is low. Each request produces exactly one result, shown on
// the o_ ports for a single cycle while o_valid is high; the receiver cannot
// hold results off, so it must take them as they come.
// Configuration (screen format, scroll start, upper-case forcing) is written
// through i_cfg_we, i_cfg_index and i_cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// A newline blanks cells up to the start of the next line; a scroll moves
// the cells after the scroll start up by one line and blanks the last line;
// clear screen writes every screen cell. A new request may be accepted in
// the cycle in which the previous result is shown. All sweeps go through
// the single write port of the screen memory, one cell per cycle.
// After reset the block is busy while it fills the screen memory with
// spaces; the cursor, the configuration registers and o_valid return to zero.
// ----------------------------------------------------------------------------
module text_console_output (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_cmd,
    input  logic [7:0]                  i_char_code,
    input  logic [6:0]                  i_column,
    input  logic [4:0]                  i_row,
    input  logic [tco_pkg::ADDR_W-1:0]  i_cell_address,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tco_pkg::ADDR_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    output logic [7:0]                  o_cell_data,
    output logic [tco_pkg::ADDR_W-1:0]  o_cursor_position,
    output logic                        o_did_scroll,
    output logic                        o_bad_position
);

    // Configuration registers.
    logic                       r_wide;
    logic [tco_pkg::ADDR_W-1:0] r_scroll_start;
    logic                       r_upper;
    tco_pkg::t_cfg              cfg;

    // Result register; it parts the sequencer from the receiver.
    logic                       r_valid;
    logic [7:0]                 r_cell_data;
    logic [tco_pkg::ADDR_W-1:0] r_cursor;
    logic                       r_scrolled;
    logic                       r_bad;

    tco_pkg::t_mem_req          mem_req;
    tco_pkg::t_result           result;
    logic [7:0]                 rd_data;
    logic                       seq_busy;

    // Writes with an index beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide         <= 1'b0;
            r_scroll_start <= '0;
            r_upper        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tco_pkg::CFG_WIDE:   r_wide         <= i_cfg_data[0];
                tco_pkg::CFG_SCROLL: r_scroll_start <= i_cfg_data;
                tco_pkg::CFG_UPPER:  r_upper        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.wide         = r_wide;
    assign cfg.scroll_start = r_scroll_start;
    assign cfg.upper        = r_upper;

    tco_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_cell_address (i_cell_address),
        .i_cfg          (cfg),
        .i_rd_data      (rd_data),
        .o_busy         (seq_busy),
        .o_mem_req      (mem_req),
        .o_result       (result)
    );

    tco_screen_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // The strobe lasts exactly one cycle, as the sequencer finishes once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_cell_data <= result.data;
            r_cursor    <= result.cursor;
            r_scrolled  <= result.scrolled;
            r_bad       <= result.bad;
        end
    end

    assign busy              = seq_busy;
    assign o_valid           = r_valid;
    assign o_cell_data       = r_cell_data;
    assign o_cursor_position = r_cursor;
    assign o_did_scroll      = r_scrolled;
    assign o_bad_position    = r_bad;

endmodule

>>> src/tco_checker.sv
// ----------------------------------------------------------------------------
// Text console checker
// Port-level checks of the request and result behaviour, bound to the top.
// ----------------------------------------------------------------------------
`include "text_console_output_macros.svh"

module tco_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [7:0] o_cell_data,
    input logic       o_did_scroll,
    input logic       o_bad_position
);

    // A result is only shown once the block is ready again.
    `TCO_ASSERT_SAME(a_valid_when_idle, o_valid, !busy)

    // An accepted request always keeps the block busy for the following cycle.
    `TCO_ASSERT_NEXT(a_accept_makes_busy, start && !busy, busy)

    // One request gives one strobe, never two in a row.
    `TCO_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid)

    // A rejected position never carries data, and never comes with a scroll.
    `TCO_ASSERT_SAME(a_bad_no_data, o_valid && o_bad_position,
        o_cell_data == 8'd0 && !o_did_scroll)

endmodule

bind text_console_output tco_checker u_tco_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_cell_data    (o_cell_data),
    .o_did_scroll   (o_did_scroll),
    .o_bad_position (o_bad_position)
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Text console output - testbench
// Drives requests into the console, mirrors its screen memory and cursor in a
// scoreboard and checks every result field by field, across several screen
// formats, scroll starts and case settings.
// ----------------------------------------------------------------------------
module tb_top;

    // The slowest request is a newline that scrolls the whole wide screen;
    // the limit covers every request being that slow, plus the clearing
    // pass after reset, several times over.
    localparam int CYCLE_LIMIT     = 7_000_000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PHASES          = 6;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PICK_RANDOM     = -1;
    localparam int ADDR_W          = tco_pkg::ADDR_W;

    typedef struct packed {
        tco_pkg::t_cmd     cmd;
        logic [7:0]        char_code;
        logic [6:0]        column;
        logic [4:0]        row;
        logic [ADDR_W-1:0] cell_address;
    } t_console_request;

    typedef struct packed {
        logic [7:0]        cell_data;
        logic [ADDR_W-1:0] cursor_position;
        logic              did_scroll;
        logic              bad_position;
    } t_console_outcome;

    // The scoreboard keeps its own copy of the screen memory, the cursor and
    // the three registers. Each accepted request is played against that copy
    // at once, and the outcome it should produce joins the queue of outcomes
    // still to come from the block.
    class screen_scoreboard;
        logic [7:0]       screen [tco_pkg::MEM_CELLS];
        int               cursor;
        bit               wide;
        int               scroll_start;
        bit               upper;
        t_console_outcome expected_outcomes [$];
        int               mismatches;

        function new();
            foreach (screen[i]) screen[i] = tco_pkg::CH_SPACE;
            cursor       = 0;
            wide         = 1'b0;
            scroll_start = 0;
            upper        = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_format(bit wide_cols, int start_cell, bit force_upper);
            wide         = wide_cols;
            scroll_start = start_cell;
            upper        = force_upper;
        endfunction

        function int columns();
            return wide ? tco_pkg::COLS_WIDE : tco_pkg::COLS_NARROW;
        endfunction

        function int cells();
            return wide ? tco_pkg::CELLS_WIDE : tco_pkg::CELLS_NARROW;
        endfunction

        function int line_after(int pos);
            if (wide) begin
                return (pos / tco_pkg::COLS_WIDE + 1) * tco_pkg::COLS_WIDE;
            end
            return (pos + tco_pkg::COLS_NARROW) & ~(tco_pkg::COLS_NARROW - 1);
        endfunction

        // Blanks from the cursor up to the start of the next line, never past
        // the top of the memory.
        function void blank_line_tail();
            int stop;
            stop = line_after(cursor);
            if (stop > tco_pkg::MEM_CELLS) begin
                stop = tco_pkg::MEM_CELLS;
            end
            for (int i = cursor; i < stop; i++) begin
                screen[i] = tco_pkg::CH_SPACE;
            end
        endfunction

        // Moves to the next line, scrolling when it falls off the screen.
        function bit advance_line();
            int w;
            int s;
            int nxt;
            w   = columns();
            s   = cells();
            nxt = line_after(cursor);
            if (nxt < s) begin
                cursor = nxt;
                return 1'b0;
            end
            if (scroll_start + w < s) begin
                for (int i = scroll_start; i < s - w; i++) begin
                    screen[i] = screen[i + w];
                end
            end
            cursor = (s / w - 1) * w;
            blank_line_tail();
            return 1'b1;
        endfunction

        function t_console_outcome predict_outcome(t_console_request req);
            t_console_outcome res;
            logic [7:0]       ch;
            int               pos;
            res = '0;
            ch  = req.char_code;
            case (req.cmd)
                tco_pkg::CMD_PUT_CHAR: begin
                    if (ch == tco_pkg::CH_BACKSPACE) begin
                        screen[cursor] = tco_pkg::CH_SPACE;
                        if (cursor != 0) begin
                            cursor--;
                        end
                    end else if (ch == tco_pkg::CH_NEWLINE) begin
                        blank_line_tail();
                        res.did_scroll = advance_line();
                    end else if (ch != tco_pkg::CH_RETURN) begin
                        if (upper && ch >= tco_pkg::CH_LOWER_A
                                  && ch <= tco_pkg::CH_LOWER_Z) begin
                            ch = ch - tco_pkg::CASE_OFFSET;
                        end
                        screen[cursor] = ch;
                        if (cursor + 1 >= cells()) begin
                            res.did_scroll = advance_line();
                        end else begin
                            cursor++;
                        end
                    end
                end
                tco_pkg::CMD_SET_CURSOR: begin
                    pos = int'(req.row) * columns() + int'(req.column);
                    if (int'(req.column) >= columns() || pos >= cells()) begin
                        res.bad_position = 1'b1;
                    end else begin
                        cursor = pos;
                    end
                end
                tco_pkg::CMD_CLEAR: begin
                    for (int i = 0; i < cells(); i++) begin
                        screen[i] = ch;
                    end
                    cursor = 0;
                end
                default: begin
                    if (int'(req.cell_address) >= cells()) begin
                        res.bad_position = 1'b1;
                    end else begin
                        res.cell_data = screen[req.cell_address];
                    end
                end
            endcase
            res.cursor_position = cursor[ADDR_W-1:0];
            return res;
        endfunction

        function void note_request(t_console_request req);
            expected_outcomes.push_back(predict_outcome(req));
        endfunction

        function void check_outcome(t_console_outcome got);
            t_console_outcome want;
            if (expected_outcomes.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.cell_data !== want.cell_data) begin
                $error("cell_data: expected 0x%02h, actual 0x%02h",
                       want.cell_data, got.cell_data);
                mismatches++;
            end
            if (got.cursor_position !== want.cursor_position) begin
                $error("cursor_position: expected %0d, actual %0d",
                       want.cursor_position, got.cursor_position);
                mismatches++;
            end
            if (got.did_scroll !== want.did_scroll) begin
                $error("did_scroll: expected %0b, actual %0b",
                       want.did_scroll, got.did_scroll);
                mismatches++;
            end
            if (got.bad_position !== want.bad_position) begin
                $error("bad_position: expected %0b, actual %0b",
                       want.bad_position, got.bad_position);
                mismatches++;
            end
        endfunction
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              busy;
    logic [1:0]        i_cmd          = tco_pkg::CMD_PUT_CHAR;
    logic [7:0]        i_char_code    = '0;
    logic [6:0]        i_column       = '0;
    logic [4:0]        i_row          = '0;
    logic [ADDR_W-1:0] i_cell_address = '0;
    logic              i_cfg_we       = 1'b0;
    logic [1:0]        i_cfg_index    = tco_pkg::CFG_WIDE;
    logic [ADDR_W-1:0] i_cfg_data     = '0;
    logic              o_valid;
    logic [7:0]        o_cell_data;
    logic [ADDR_W-1:0] o_cursor_position;
    logic              o_did_scroll;
    logic              o_bad_position;

    screen_scoreboard tracker = new();
    bit               idle_allowed = 1'b1;
    int               cycle_count = 0;

    text_console_output u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_char_code       (i_char_code),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_cell_address    (i_cell_address),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_cell_data       (o_cell_data),
        .o_cursor_position (o_cursor_position),
        .o_did_scroll      (o_did_scroll),
        .o_bad_position    (o_bad_position)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // A run that overstays the limit counts as a failure.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Results cannot be held off, so every cycle with o_valid high carries
    // one. The ports are sampled at the edge that ends that cycle, before the
    // block updates them.
    always @(posedge i_clk) begin
        t_console_outcome got;
        if (i_rst_n && o_valid) begin
            got.cell_data       = o_cell_data;
            got.cursor_position = o_cursor_position;
            got.did_scroll      = o_did_scroll;
            got.bad_position    = o_bad_position;
            tracker.check_outcome(got);
        end
    end

    // Offers one request and returns in the time step of the edge that took
    // it. Start is left high so that a following request can go out straight
    // away; an idle burst, where allowed, lowers it first. The busy value
    // read just after the edge is the one the block saw at that edge.
    task automatic issue_request(input tco_pkg::t_cmd cmd, input logic [7:0] ch,
                                 input logic [6:0] col, input logic [4:0] row,
                                 input logic [ADDR_W-1:0] addr);
        t_console_request req;
        req = '{cmd: cmd, char_code: ch, column: col, row: row, cell_address: addr};
        if (idle_allowed && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_char_code    <= ch;
        i_column       <= col;
        i_row          <= row;
        i_cell_address <= addr;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        tracker.note_request(req);
    endtask

    // Registers may only change while the block is idle: start is dropped,
    // every outstanding result is collected and busy must be low. The three
    // registers then go in on consecutive edges.
    task automatic apply_settings(input bit wide_cols, input int start_cell,
                                  input bit force_upper);
        start <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tco_pkg::CFG_WIDE;
        i_cfg_data  <= ADDR_W'(wide_cols);
        @(posedge i_clk);
        i_cfg_index <= tco_pkg::CFG_SCROLL;
        i_cfg_data  <= ADDR_W'(start_cell);
        @(posedge i_clk);
        i_cfg_index <= tco_pkg::CFG_UPPER;
        i_cfg_data  <= ADDR_W'(force_upper);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_format(wide_cols, start_cell, force_upper);
    endtask

    // Random requests lean towards what reaches the deeper behaviour: the
    // cursor is often placed near the end of the last line so that printing
    // and newlines scroll, while a share of fully random fields keeps the
    // off-screen cases and every field bit exercised. Clears are rare since
    // each walks the whole screen.
    function automatic t_console_request random_request();
        t_console_request r;
        int               pick;
        int               sub;
        int               w;
        int               lines;
        w              = tracker.columns();
        lines          = tracker.cells() / w;
        r.cmd          = tco_pkg::CMD_PUT_CHAR;
        r.char_code    = 8'($urandom);
        r.column       = 7'($urandom);
        r.row          = 5'($urandom);
        r.cell_address = ADDR_W'($urandom);
        pick           = $urandom_range(0, 99);
        sub            = $urandom_range(0, 19);
        if (pick < 50) begin
            if (sub < 2) begin
                r.char_code = tco_pkg::CH_BACKSPACE;
            end else if (sub < 4) begin
                r.char_code = tco_pkg::CH_NEWLINE;
            end else if (sub < 5) begin
                r.char_code = tco_pkg::CH_RETURN;
            end else if (sub < 12) begin
                r.char_code = 8'($urandom_range(32, 126));
            end else if (sub < 15) begin
                r.char_code = 8'($urandom_range(tco_pkg::CH_LOWER_A,
                                                tco_pkg::CH_LOWER_Z));
            end
        end else if (pick < 72) begin
            r.cmd = tco_pkg::CMD_SET_CURSOR;
            if (sub < 10) begin
                r.row    = 5'(lines - 1);
                r.column = 7'(w - 1 - $urandom_range(0, 7));
            end else if (sub < 16) begin
                r.row    = 5'($urandom_range(0, lines - 1));
                r.column = 7'($urandom_range(0, w - 1));
            end
        end else if (pick < 74) begin
            r.cmd = tco_pkg::CMD_CLEAR;
        end else begin
            r.cmd = tco_pkg::CMD_READ_CELL;
            if (sub < 10) begin
                r.cell_address = ADDR_W'($urandom_range(0, tracker.cells() - 1));
            end
        end
        return r;
    endfunction

    initial begin
        t_console_request req;
        int               phase_wide   [PHASES];
        int               phase_scroll [PHASES];
        int               phase_upper  [PHASES];
        int               start_cell;
        bit               force_upper;

        phase_wide   = '{1, 0, 1, 0, 1, 0};
        phase_scroll = '{0, 0, 1919, 960, PICK_RANDOM, PICK_RANDOM};
        phase_upper  = '{0, 1, 0, 1, PICK_RANDOM, 1};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first on the reset settings: narrow screen, scroll
        // from the top, no case forcing. The block clears its memory after
        // reset, so the first request simply waits on busy.
        issue_request(tco_pkg::CMD_READ_CELL, 8'h00, 7'd0, 5'd0, 11'd0);
        // Backspace with the cursor already at the home position.
        issue_request(tco_pkg::CMD_PUT_CHAR, tco_pkg::CH_BACKSPACE, 7'd0, 5'd0, 11'd0);
        // A lower-case letter passes through untouched when forcing is off.
        issue_request(tco_pkg::CMD_PUT_CHAR, 8'h61, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_PUT_CHAR, tco_pkg::CH_RETURN, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_PUT_CHAR, 8'h00, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_PUT_CHAR, tco_pkg::CH_NEWLINE, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_PUT_CHAR, tco_pkg::CH_BACKSPACE, 7'd0, 5'd0, 11'd0);
        // Printing into the very last cell scrolls the whole screen.
        issue_request(tco_pkg::CMD_SET_CURSOR, 8'h00, 7'd63, 5'd15, 11'd0);
        issue_request(tco_pkg::CMD_PUT_CHAR, 8'hFF, 7'd0, 5'd0, 11'd0);
        // Off-screen positions: a column past the line, then every bit set.
        issue_request(tco_pkg::CMD_SET_CURSOR, 8'h00, 7'd64, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_SET_CURSOR, 8'hFF, 7'd127, 5'd31, 11'd2047);
        issue_request(tco_pkg::CMD_READ_CELL, 8'hFF, 7'd127, 5'd31, 11'd2047);
        issue_request(tco_pkg::CMD_READ_CELL, 8'h00, 7'd0, 5'd0, 11'd1023);
        // A newline on the last line scrolls as well.
        issue_request(tco_pkg::CMD_SET_CURSOR, 8'h00, 7'd0, 5'd15, 11'd0);
        issue_request(tco_pkg::CMD_PUT_CHAR, tco_pkg::CH_NEWLINE, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_CLEAR, 8'h00, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_READ_CELL, 8'h00, 7'd0, 5'd0, 11'd1023);

        // Wide screen, scroll start inside the last line, upper case forced:
        // a scroll then moves nothing but still blanks the last line.
        apply_settings(1'b1, 1919, 1'b1);
        issue_request(tco_pkg::CMD_PUT_CHAR, tco_pkg::CH_LOWER_Z, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_PUT_CHAR, 8'h7B, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_SET_CURSOR, 8'h00, 7'd79, 5'd23, 11'd0);
        issue_request(tco_pkg::CMD_PUT_CHAR, 8'h71, 7'd0, 5'd0, 11'd0);
        issue_request(tco_pkg::CMD_SET_CURSOR, 8'h00, 7'd0, 5'd24, 11'd0);
        issue_request(tco_pkg::CMD_READ_CELL, 8'h00, 7'd0, 5'd0, 11'd1919);
        issue_request(tco_pkg::CMD_SET_CURSOR, 8'h00, 7'd40, 5'd23, 11'd0);

        // Back to the narrow screen with the cursor left beyond its end: the
        // newline blanks the rest of the old line and then scrolls.
        apply_settings(1'b0, 100, 1'b0);
        issue_request(tco_pkg::CMD_PUT_CHAR, tco_pkg::CH_NEWLINE, 7'd0, 5'd0, 11'd0);

        // Random part, one setting per phase; the last phase runs without
        // idle gaps so that requests follow each other as fast as possible.
        for (int p = 0; p < PHASES; p++) begin
            start_cell  = (phase_scroll[p] == PICK_RANDOM) ?
                          $urandom_range(0, 1919) : phase_scroll[p];
            force_upper = (phase_upper[p] == PICK_RANDOM) ?
                          1'($urandom) : 1'(phase_upper[p]);
            apply_settings(1'(phase_wide[p]), start_cell, force_upper);
            idle_allowed = (p != PHASES - 1);
            repeat (ITEMS_PER_PHASE) begin
                req = random_request();
                issue_request(req.cmd, req.char_code, req.column, req.row,
                              req.cell_address);
            end
        end

        start <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        // The drain that follows catches any stray result after the last one.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/tco_pkg.sv
src/tco_screen_mem.sv
src/tco_seq.sv
src/text_console_output.sv
src/tco_checker.sv
bench/tb_top.sv
